// ===== rtl/core/qsu_pkg.sv =====
// Shared widths, stage payload types and lane codes for the quadratic solver.
// Depends on nothing; every other file imports it.
package qsu_pkg;

  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 16;

  localparam int DISC_W = 2 * COEF_BITS + 2;
  localparam int SQ_N   = DISC_W / 2 + FRAC_BITS;
  localparam int REM_W  = SQ_N + 2;
  localparam int NB_W   = COEF_BITS + FRAC_BITS + 1;
  localparam int DVD_W  = DISC_W + FRAC_BITS;
  localparam int DVS_W  = COEF_BITS + 2;
  localparam int ROOT_W = 40;
  localparam int VY_W   = 48;
  localparam int CNT_W  = 2;

  localparam int IN_W  = 48;
  localparam int OUT_W = 208;

  localparam int N_LANE  = 4;
  localparam int LANE_LO = 0;
  localparam int LANE_HI = 1;
  localparam int LANE_VX = 2;
  localparam int LANE_VY = 3;

  localparam logic [CNT_W-1:0] CNT_NONE = 2'd0;
  localparam logic [CNT_W-1:0] CNT_ONE  = 2'd1;
  localparam logic [CNT_W-1:0] CNT_TWO  = 2'd2;

  typedef struct packed {
    logic                        zero_lead;
    logic signed [DISC_W-1:0]    disc;
    logic signed [COEF_BITS-1:0] a;
    logic signed [NB_W-1:0]      nb;
  } disc_item_t;

  typedef struct packed {
    disc_item_t        base;
    logic [SQ_N-1:0]   s;
  } root_item_t;

  typedef struct packed {
    logic                     zero_lead;
    logic signed [DISC_W-1:0] disc;
  } div_side_t;

endpackage

// ===== rtl/core/qsu_disc.sv =====
// Discriminant front end: registered products, then b*b - 4ac and -b scaled.
// Depends on qsu_pkg.
module qsu_disc import qsu_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_vld,
  input  logic signed [COEF_BITS-1:0] a,
  input  logic signed [COEF_BITS-1:0] b,
  input  logic signed [COEF_BITS-1:0] c,
  output logic                        out_vld,
  output disc_item_t                  out_item
);

  logic                          v1_r, v2_r;
  logic signed [2*COEF_BITS-1:0] bb_r, ac_r;
  logic signed [COEF_BITS-1:0]   a1_r, b1_r;
  disc_item_t                    it_r, it_nxt;
  logic signed [NB_W-1:0]        bw;

  always_comb begin
    bw = NB_W'(b1_r);
    it_nxt.zero_lead = (a1_r == '0);
    it_nxt.disc = DISC_W'(bb_r) - (DISC_W'(ac_r) <<< 2);
    it_nxt.a = a1_r;
    it_nxt.nb = -(bw <<< FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
    if (adv) begin
      bb_r <= b * b;
      ac_r <= a * c;
      a1_r <= a;
      b1_r <= b;
      it_r <= it_nxt;
    end
  end

  assign out_vld  = v2_r;
  assign out_item = it_r;

endmodule

// ===== rtl/core/qsu_sqrt_pipe.sv =====
// Bit-pair square root, one result bit per pipeline stage, of D * 4^FRAC_BITS.
// Depends on qsu_pkg.
module qsu_sqrt_pipe import qsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_vld,
  input  disc_item_t in_item,
  output logic       out_vld,
  output root_item_t out_item
);

  logic              vld_r  [SQ_N+1];
  disc_item_t        it_r   [SQ_N+1];
  logic [DISC_W-1:0] rad_r  [SQ_N+1];
  logic [SQ_N-1:0]   root_r [SQ_N+1];
  logic [REM_W-1:0]  rem_r  [SQ_N+1];

  // stage 0 latches the radicand; a negative discriminant is never rooted
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_vld;
    if (adv) begin
      it_r[0]   <= in_item;
      rad_r[0]  <= in_item.disc[DISC_W-1] ? '0 : in_item.disc;
      root_r[0] <= '0;
      rem_r[0]  <= '0;
    end
  end

  for (genvar j = 0; j < SQ_N; j++) begin : g_stage
    localparam int I = SQ_N - 1 - j;
    logic [1:0]       pair;
    logic [REM_W-1:0] trial, t;
    logic             ge;

    if (I >= FRAC_BITS) begin : g_pair
      assign pair = rad_r[j][2*(I-FRAC_BITS) +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      trial = {rem_r[j][REM_W-3:0], pair};
      t     = {root_r[j], 2'b01};
      ge    = (trial >= t);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[j+1] <= 1'b0;
      else if (adv) vld_r[j+1] <= vld_r[j];
      if (adv) begin
        it_r[j+1]   <= it_r[j];
        rad_r[j+1]  <= rad_r[j];
        root_r[j+1] <= {root_r[j][SQ_N-2:0], ge};
        rem_r[j+1]  <= ge ? trial - t : trial;
      end
    end
  end

  assign out_vld       = vld_r[SQ_N];
  assign out_item.base = it_r[SQ_N];
  assign out_item.s    = root_r[SQ_N];

endmodule

// ===== rtl/core/qsu_div_pipe.sv =====
// Four restoring dividers in lockstep, one quotient bit per stage, truncating
// toward zero. Lanes: low candidate, high candidate, vertex x, vertex y. Uses qsu_pkg.
module qsu_div_pipe import qsu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  root_item_t               in_item,
  output logic                     out_vld,
  output div_side_t                out_side,
  output logic signed [DVD_W:0]    quo [N_LANE]
);

  logic              vld_r  [DVD_W+1];
  div_side_t         side_r [DVD_W+1];
  logic [DVS_W-1:0]  dvs_r  [DVD_W+1][N_LANE];
  logic [DVS_W-1:0]  rem_r  [DVD_W+1][N_LANE];
  logic [DVD_W-1:0]  work_r [DVD_W+1][N_LANE];
  logic              neg_r  [DVD_W+1][N_LANE];

  logic signed [DVD_W:0]   num [N_LANE];
  logic signed [DVS_W-1:0] den [N_LANE];
  logic signed [DVD_W:0]   nbw, sw, dw;
  logic signed [DVS_W-1:0] aw;

  always_comb begin
    nbw = (DVD_W+1)'(in_item.base.nb);
    sw  = (DVD_W+1)'({1'b0, in_item.s});
    dw  = (DVD_W+1)'(in_item.base.disc);
    aw  = DVS_W'(in_item.base.a);
    num[LANE_LO] = nbw - sw;
    num[LANE_HI] = nbw + sw;
    num[LANE_VX] = nbw;
    num[LANE_VY] = -(dw <<< FRAC_BITS);
    den[LANE_LO] = aw <<< 1;
    den[LANE_HI] = aw <<< 1;
    den[LANE_VX] = aw <<< 1;
    den[LANE_VY] = aw <<< 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else if (adv) vld_r[0] <= in_vld;
    if (adv) begin
      side_r[0].zero_lead <= in_item.base.zero_lead;
      side_r[0].disc      <= in_item.base.disc;
      for (int l = 0; l < N_LANE; l++) begin
        work_r[0][l] <= num[l][DVD_W] ? DVD_W'(-num[l]) : DVD_W'(num[l]);
        dvs_r[0][l]  <= den[l][DVS_W-1] ? DVS_W'(-den[l]) : DVS_W'(den[l]);
        rem_r[0][l]  <= '0;
        neg_r[0][l]  <= num[l][DVD_W] ^ den[l][DVS_W-1];
      end
    end
  end

  for (genvar k = 0; k < DVD_W; k++) begin : g_stage
    logic [DVS_W:0]   trial [N_LANE];
    logic             ge    [N_LANE];
    logic [DVS_W-1:0] rem_nxt [N_LANE];

    always_comb begin
      for (int l = 0; l < N_LANE; l++) begin
        trial[l]   = {rem_r[k][l], work_r[k][l][DVD_W-1]};
        ge[l]      = (trial[l] >= {1'b0, dvs_r[k][l]});
        rem_nxt[l] = ge[l] ? DVS_W'(trial[l] - {1'b0, dvs_r[k][l]}) : DVS_W'(trial[l]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[k+1] <= 1'b0;
      else if (adv) vld_r[k+1] <= vld_r[k];
      if (adv) begin
        side_r[k+1] <= side_r[k];
        for (int l = 0; l < N_LANE; l++) begin
          dvs_r[k+1][l]  <= dvs_r[k][l];
          rem_r[k+1][l]  <= rem_nxt[l];
          work_r[k+1][l] <= {work_r[k][l][DVD_W-2:0], ge[l]};
          neg_r[k+1][l]  <= neg_r[k][l];
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < N_LANE; l++) begin
      quo[l] = neg_r[DVD_W][l] ? -$signed({1'b0, work_r[DVD_W][l]})
                               : $signed({1'b0, work_r[DVD_W][l]});
    end
  end

  assign out_vld  = vld_r[DVD_W];
  assign out_side = side_r[DVD_W];

endmodule

// ===== rtl/core/quadratic_solver_unit.sv =====
// Quadratic solver top: discriminant, pipelined square root and dividers, result register.
// Throughput: one transaction per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears the stage valid bits only; no memory to sweep.
// Depends on qsu_pkg, qsu_disc, qsu_sqrt_pipe, qsu_div_pipe.
module quadratic_solver_unit import qsu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // coef_a[15:0], coef_b[31:16], coef_c[47:32]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // disc_value[33:0], root_count[35:34], root_low[75:36], root_high[115:76],
  // vertex_x[155:116], vertex_y[203:156], zero padding[207:204]
  output logic [OUT_W-1:0] out_tdata,
  // zero_leading[0]
  output logic             out_tuser
);

  logic                  adv;
  logic                  d_vld, s_vld, q_vld;
  disc_item_t            d_item;
  root_item_t            s_item;
  div_side_t             q_side;
  logic signed [DVD_W:0] quo [N_LANE];

  logic                    vld_r;
  logic [OUT_W-1:0]        data_r, data_nxt;
  logic                    user_r;
  logic [CNT_W-1:0]        cnt;
  logic signed [DVD_W:0]   lo, hi;

  assign adv = !vld_r || out_tready;
  assign in_tready = adv;

  qsu_disc u_disc (
    .clk, .rst_n, .adv,
    .in_vld   (in_tvalid),
    .a        (in_tdata[COEF_BITS-1:0]),
    .b        (in_tdata[2*COEF_BITS-1:COEF_BITS]),
    .c        (in_tdata[3*COEF_BITS-1:2*COEF_BITS]),
    .out_vld  (d_vld),
    .out_item (d_item)
  );

  qsu_sqrt_pipe u_sqrt (
    .clk, .rst_n, .adv,
    .in_vld   (d_vld),
    .in_item  (d_item),
    .out_vld  (s_vld),
    .out_item (s_item)
  );

  qsu_div_pipe u_div (
    .clk, .rst_n, .adv,
    .in_vld   (s_vld),
    .in_item  (s_item),
    .out_vld  (q_vld),
    .out_side (q_side),
    .quo      (quo)
  );

  always_comb begin
    lo = '0;
    hi = '0;
    if (q_side.disc[DISC_W-1]) begin
      cnt = CNT_NONE;
    end else if (q_side.disc == '0) begin
      cnt = CNT_ONE;
      lo  = quo[LANE_VX];
    end else begin
      cnt = CNT_TWO;
      if (quo[LANE_LO] < quo[LANE_HI]) begin
        lo = quo[LANE_LO];
        hi = quo[LANE_HI];
      end else begin
        lo = quo[LANE_HI];
        hi = quo[LANE_LO];
      end
    end
    data_nxt = '0;
    if (!q_side.zero_lead) begin
      data_nxt[DISC_W-1:0]         = q_side.disc;
      data_nxt[DISC_W +: CNT_W]    = cnt;
      data_nxt[36 +: ROOT_W]       = lo[ROOT_W-1:0];
      data_nxt[76 +: ROOT_W]       = hi[ROOT_W-1:0];
      data_nxt[116 +: ROOT_W]      = quo[LANE_VX][ROOT_W-1:0];
      data_nxt[156 +: VY_W]        = quo[LANE_VY][VY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (adv) vld_r <= q_vld;
    if (adv) begin
      data_r <= data_nxt;
      user_r <= q_side.zero_lead;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;

  a_zero_lead_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero leading result carries nonzero fields");

  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[DISC_W +: CNT_W] != 2'b11)
    else $error("root count out of range");

  a_roots_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[DISC_W +: CNT_W] == CNT_TWO
      |-> $signed(out_tdata[36 +: ROOT_W]) <= $signed(out_tdata[76 +: ROOT_W]))
    else $error("roots out of order");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result moved during stall");

endmodule
